// ===== rtl/sasc_pkg.sv =====
package sasc_pkg;

    localparam int ANG_W     = 16;
    localparam int RATE_W    = 16;
    localparam int SPEED_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

    localparam logic [CFG_W-1:0] RADIUS_RST = 16'd410;
    localparam logic [CFG_W-1:0] LENGTH_RST = 16'd2048;

    // Angles in Q12
    localparam logic [15:0] PI_Q12      = 16'd12868;
    localparam logic [15:0] TWO_PI_Q12  = 16'd25736;
    localparam logic [15:0] FOUR_PI_Q12 = 16'd51472;
    localparam logic [12:0] HALF_PI_Q12 = 13'd6434;

    // Speed scale in unsigned Q16
    localparam logic [16:0] SCALE_ONE   = 17'd65536;
    localparam logic [16:0] SCALE_FLOOR = 17'd655;
    localparam logic [12:0] LOW_LIMIT   = 13'd820;
    localparam logic [12:0] HIGH_LIMIT  = 13'd4096;

    // Quotient bits of the turn-rate divide; anything wider saturates anyway
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic              op;
        logic              has_steer_one;
        logic              has_steer_two;
        logic [ANG_W-1:0]  angle_one;
        logic [ANG_W-1:0]  angle_two;
        logic              has_wheel_one;
        logic              has_wheel_two;
        logic [RATE_W-1:0] wheel_rate_one;
        logic [RATE_W-1:0] wheel_rate_two;
    } t_in_item;

    typedef struct packed {
        logic               drive_one_valid;
        logic [SPEED_W-1:0] drive_one_linear;
        logic [SPEED_W-1:0] drive_one_angular;
        logic               drive_two_valid;
        logic [SPEED_W-1:0] drive_two_linear;
        logic [SPEED_W-1:0] drive_two_angular;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic store_meas;
        logic reduce;
        logic fold;
        logic square;
        logic cube;
        logic scale;
        logic lin_mul;
        logic lin_scale;
        logic lin_round;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    function automatic logic [SPEED_W-1:0] sat16(input logic neg, input logic [20:0] mag);
        logic [20:0] negm;
        negm = ~mag + 21'd1;
        if (neg) begin
            sat16 = (mag > 21'd32768) ? 16'h8000 : negm[15:0];
        end else begin
            sat16 = (mag > 21'd32767) ? 16'h7fff : mag[15:0];
        end
    endfunction

endpackage

// ===== rtl/steering_align_speed_scaler.sv =====
// Two-drive steering coordinator. A measure item (op 0) stores the flagged
// steering angles when it is accepted and gives no result. A command item
// (op 1) with at least one wheel present has its result loaded into the
// output register after eight steps and a divide. The steps are wrap, fold
// and clamp of the error, two multiplies for the cube, the speed scale, and
// two multiplies for the linear speed with rounding. The divide is a
// restoring divide for the turn rate, one quotient bit per cycle. The load
// waits while an earlier result is still held in the output register. The
// input is stalled from the accepting edge until that load, so the block
// takes no new item while a command is in flight. Both drives run side by
// side in the same steps. A command with no wheel gives no result and is
// done when it is accepted. A finished result sits in the output register,
// and the next item is taken while it waits. Register writes (index 0 wheel
// radius, 1 drive length) are always ready and must only be issued while no
// command is in flight.
module steering_align_speed_scaler import sasc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    sasc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .i_any_wheel (i_in.has_wheel_one || i_in.has_wheel_two),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sasc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/sasc_ctrl.sv =====
module sasc_ctrl import sasc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_any_wheel,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_REDUCE    = 4'd1;
    localparam logic [3:0] ST_FOLD      = 4'd2;
    localparam logic [3:0] ST_SQUARE    = 4'd3;
    localparam logic [3:0] ST_CUBE      = 4'd4;
    localparam logic [3:0] ST_SCALE     = 4'd5;
    localparam logic [3:0] ST_LIN_MUL   = 4'd6;
    localparam logic [3:0] ST_LIN_SCALE = 4'd7;
    localparam logic [3:0] ST_LIN_ROUND = 4'd8;
    localparam logic [3:0] ST_DIVIDE    = 4'd9;
    localparam logic [3:0] ST_DONE      = 4'd10;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_MEASURE) begin
                        o_cmd.store_meas = 1'b1;
                    end else if (i_any_wheel) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_CUBE;
            end
            ST_CUBE: begin
                o_cmd.cube = 1'b1;
                n_state    = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_LIN_MUL;
            end
            ST_LIN_MUL: begin
                o_cmd.lin_mul = 1'b1;
                n_state       = ST_LIN_SCALE;
            end
            ST_LIN_SCALE: begin
                o_cmd.lin_scale = 1'b1;
                n_state         = ST_LIN_ROUND;
            end
            ST_LIN_ROUND: begin
                o_cmd.lin_round = 1'b1;
                n_cnt           = '0;
                n_state         = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/sasc_dp.sv =====
module sasc_dp import sasc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_out_item            o_out
);

    logic [CFG_W-1:0]  r_radius;
    logic [CFG_W-1:0]  r_length;
    logic [ANG_W-1:0]  r_meas [2];

    logic [1:0]        r_hw;
    logic [1:0]        r_rneg;
    logic [15:0]       r_rmag [2];
    logic [1:0]        r_esgn;
    logic [15:0]       r_dmag [2];
    logic [12:0]       r_emag [2];
    logic [25:0]       r_sq [2];
    logic [38:0]       r_cube [2];
    logic [16:0]       r_smin;
    logic [31:0]       r_p1 [2];
    logic [48:0]       r_p2 [2];
    logic [SPEED_W-1:0] r_lin [2];
    logic [19:0]       r_dvs;
    logic [19:0]       r_rem [2];
    logic [16:0]       r_nlo [2];
    logic [16:0]       r_quo [2];
    logic [1:0]        r_ovf;
    t_out_item         r_out;

    logic [ANG_W-1:0]  w_ang [2];
    logic [1:0]        w_hs;
    logic [RATE_W-1:0] w_rate [2];
    logic [16:0]       w_diff [2];
    logic [16:0]       w_dneg [2];
    logic [15:0]       w_dmag [2];
    logic [15:0]       w_rneg_mag [2];
    logic [15:0]       w_red [2];
    logic [1:0]        w_flip;
    logic [15:0]       w_fold [2];
    logic [12:0]       w_clamp [2];
    logic [21:0]       w_cround [2];
    logic [16:0]       w_scale [2];
    logic [18:0]       w_den;
    logic [19:0]       w_dvs;
    logic [23:0]       w_num [2];
    logic [20:0]       w_trial [2];
    logic [1:0]        w_qbit;
    logic [48:0]       w_lround [2];
    logic [SPEED_W-1:0] w_angular [2];

    assign w_ang[0]  = i_in.angle_one;
    assign w_ang[1]  = i_in.angle_two;
    assign w_hs      = {i_in.has_steer_two, i_in.has_steer_one};
    assign w_rate[0] = i_in.wheel_rate_one;
    assign w_rate[1] = i_in.wheel_rate_two;

    assign w_den = {1'b0, r_length, 2'b00} + {3'b000, r_length};
    assign w_dvs = {w_den, 1'b0};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_diff[k]     = {r_meas[k][15], r_meas[k]} - {w_ang[k][15], w_ang[k]};
            w_dneg[k]     = ~w_diff[k] + 17'd1;
            w_dmag[k]     = w_hs[k] ? (w_diff[k][16] ? w_dneg[k][15:0] : w_diff[k][15:0])
                                    : 16'd0;
            w_rneg_mag[k] = ~w_rate[k] + 16'd1;

            // truncating remainder by two pi, magnitude only
            if (r_dmag[k] >= FOUR_PI_Q12) begin
                w_red[k] = r_dmag[k] - FOUR_PI_Q12;
            end else if (r_dmag[k] >= TWO_PI_Q12) begin
                w_red[k] = r_dmag[k] - TWO_PI_Q12;
            end else begin
                w_red[k] = r_dmag[k];
            end

            // past pi the wrapped error lies on the other side
            w_flip[k]  = (r_dmag[k] > PI_Q12);
            w_fold[k]  = w_flip[k] ? (TWO_PI_Q12 - r_dmag[k]) : r_dmag[k];
            w_clamp[k] = (w_fold[k] > {3'b000, HALF_PI_Q12}) ? HALF_PI_Q12 : w_fold[k][12:0];

            w_cround[k] = 22'((r_cube[k] + 39'd65536) >> 17);
            if (r_emag[k] < LOW_LIMIT) begin
                w_scale[k] = SCALE_ONE;
            end else if (r_emag[k] > HIGH_LIMIT) begin
                w_scale[k] = SCALE_FLOOR;
            end else if (w_cround[k] >= {5'd0, SCALE_ONE}) begin
                w_scale[k] = '0;
            end else begin
                w_scale[k] = SCALE_ONE - w_cround[k][16:0];
            end

            w_num[k]   = {1'b0, r_emag[k], 10'd0} + {5'd0, w_den};
            w_trial[k] = {r_rem[k], r_nlo[k][16]};
            w_qbit[k]  = (w_trial[k] >= {1'b0, r_dvs});

            w_lround[k] = r_p2[k] + 49'h800_0000;

            if (r_emag[k] == 13'd0) begin
                w_angular[k] = '0;
            end else if (r_ovf[k]) begin
                w_angular[k] = sat16(r_esgn[k], 21'h10000);
            end else begin
                w_angular[k] = sat16(r_esgn[k], {4'd0, r_quo[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RST;
            r_length  <= LENGTH_RST;
            r_meas[0] <= '0;
            r_meas[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_LENGTH: r_length <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store_meas) begin
                for (int k = 0; k < 2; k++) begin
                    if (w_hs[k]) begin
                        r_meas[k] <= w_ang[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.load) begin
                r_hw[k]   <= (k == 0) ? i_in.has_wheel_one : i_in.has_wheel_two;
                r_rneg[k] <= w_rate[k][15];
                r_rmag[k] <= w_rate[k][15] ? w_rneg_mag[k] : w_rate[k];
                r_esgn[k] <= w_diff[k][16];
                r_dmag[k] <= w_dmag[k];
            end
            if (i_cmd.reduce) begin
                r_dmag[k] <= w_red[k];
            end
            if (i_cmd.fold) begin
                r_esgn[k] <= r_esgn[k] ^ w_flip[k];
                r_emag[k] <= w_clamp[k];
            end
            if (i_cmd.square) begin
                r_sq[k] <= r_emag[k] * r_emag[k];
            end
            if (i_cmd.cube) begin
                r_cube[k] <= r_sq[k] * r_emag[k];
            end
            if (i_cmd.lin_mul) begin
                r_p1[k] <= r_rmag[k] * r_radius;
            end
            if (i_cmd.lin_scale) begin
                r_p2[k] <= r_p1[k] * r_smin;
            end
            if (i_cmd.lin_round) begin
                r_lin[k] <= sat16(r_rneg[k], w_lround[k][48:28]);
                r_rem[k] <= {13'd0, w_num[k][23:17]};
                r_nlo[k] <= w_num[k][16:0];
                r_quo[k] <= '0;
                r_ovf[k] <= ({13'd0, w_num[k][23:17]} >= w_dvs);
            end
            if (i_cmd.div_step) begin
                r_nlo[k] <= {r_nlo[k][15:0], 1'b0};
                r_quo[k] <= {r_quo[k][15:0], w_qbit[k]};
                if (w_qbit[k]) begin
                    r_rem[k] <= 20'(w_trial[k] - {1'b0, r_dvs});
                end else begin
                    r_rem[k] <= w_trial[k][19:0];
                end
            end
        end
        if (i_cmd.scale) begin
            r_smin <= (w_scale[0] < w_scale[1]) ? w_scale[0] : w_scale[1];
        end
        if (i_cmd.lin_round) begin
            r_dvs <= w_dvs;
        end
        if (i_cmd.load_out) begin
            r_out.drive_one_valid   <= r_hw[0];
            r_out.drive_one_linear  <= r_hw[0] ? r_lin[0] : '0;
            r_out.drive_one_angular <= r_hw[0] ? w_angular[0] : '0;
            r_out.drive_two_valid   <= r_hw[1];
            r_out.drive_two_linear  <= r_hw[1] ? r_lin[1] : '0;
            r_out.drive_two_angular <= r_hw[1] ? w_angular[1] : '0;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/sasc_chk.sv =====
module sasc_chk import sasc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_some_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.drive_one_valid || o_out.drive_two_valid))
        else $error("result without any drive");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.drive_one_valid |->
            (o_out.drive_one_linear == '0) && (o_out.drive_one_angular == '0))
        else $error("absent drive carries non-zero speeds");

    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in.op == OP_COMMAND) &&
            (i_in.has_wheel_one || i_in.has_wheel_two) |=> o_in_stall)
        else $error("command transaction not worked before next item");

    a_measure_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in.op == OP_MEASURE) && !o_out_valid |=> !o_out_valid)
        else $error("measure transaction produced a result");

endmodule

bind steering_align_speed_scaler sasc_chk u_sasc_chk (.*);

// ===== tb/sasc_drive_checker.sv =====
module sasc_drive_checker import sasc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PI_I      = int'(PI_Q12);
    localparam int     TWO_PI_I  = int'(TWO_PI_Q12);
    localparam int     HALF_PI_I = int'(HALF_PI_Q12);
    localparam longint ONE_Q16   = longint'(SCALE_ONE);
    localparam longint FLOOR_Q16 = longint'(SCALE_FLOOR);
    localparam longint LOW_I     = longint'(LOW_LIMIT);
    localparam longint HIGH_I    = longint'(HIGH_LIMIT);

    logic [CFG_W-1:0]        radius_q12;
    logic [CFG_W-1:0]        drive_length;
    logic signed [ANG_W-1:0] steer_meas [2];
    t_out_item               drive_cmd_q [$];
    int                      fails = 0;

    function automatic logic [SPEED_W-1:0] clip16(bit neg, longint mag);
        if (neg) begin
            return (mag > 32768) ? 16'h8000 : 16'(-mag);
        end
        return (mag > 32767) ? 16'h7fff : 16'(mag);
    endfunction

    // Truncating remainder, then pull back into [-pi, pi] and clamp to +-pi/2
    function automatic int fold_error(int e);
        int r;
        r = e % TWO_PI_I;
        if (r < -PI_I) begin
            r += TWO_PI_I;
        end else if (r > PI_I) begin
            r -= TWO_PI_I;
        end
        if (r > HALF_PI_I) begin
            r = HALF_PI_I;
        end else if (r < -HALF_PI_I) begin
            r = -HALF_PI_I;
        end
        return r;
    endfunction

    function automatic longint speed_scale(int e);
        longint a;
        longint cube;
        a = longint'((e < 0) ? -e : e);
        if (a < LOW_I) begin
            return ONE_Q16;
        end
        if (a > HIGH_I) begin
            return FLOOR_Q16;
        end
        cube = (a * a * a + 64'sd65536) >>> 17;
        return (cube >= ONE_Q16) ? 64'sd0 : ONE_Q16 - cube;
    endfunction

    function automatic logic [SPEED_W-1:0] linear_speed(int rate, longint scale);
        longint mag;
        mag = longint'((rate < 0) ? -rate : rate);
        mag = mag * longint'(radius_q12) * scale;
        mag = (mag + 64'sd134217728) >>> 28;
        return clip16(rate < 0, mag);
    endfunction

    function automatic logic [SPEED_W-1:0] turn_rate(int e);
        longint mag;
        longint den;
        if (e == 0) begin
            return '0;
        end
        mag = longint'((e < 0) ? -e : e) * 512;
        if (drive_length == '0) begin
            return clip16(e < 0, 64'sd65536);
        end
        den = 5 * longint'(drive_length);
        return clip16(e < 0, (2 * mag + den) / (2 * den));
    endfunction

    function automatic bit predict_drive_cmd(t_in_item it, output t_out_item cmd);
        int     err [2];
        longint s0;
        longint s1;
        longint smin;
        cmd = '0;
        if (it.op == OP_MEASURE) begin
            if (it.has_steer_one) begin
                steer_meas[0] = it.angle_one;
            end
            if (it.has_steer_two) begin
                steer_meas[1] = it.angle_two;
            end
            return 1'b0;
        end
        err[0] = it.has_steer_one ?
                 fold_error(int'(steer_meas[0]) - int'($signed(it.angle_one))) : 0;
        err[1] = it.has_steer_two ?
                 fold_error(int'(steer_meas[1]) - int'($signed(it.angle_two))) : 0;
        if (!it.has_wheel_one && !it.has_wheel_two) begin
            return 1'b0;
        end
        s0 = speed_scale(err[0]);
        s1 = speed_scale(err[1]);
        smin = (s0 < s1) ? s0 : s1;
        if (it.has_wheel_one) begin
            cmd.drive_one_valid   = 1'b1;
            cmd.drive_one_linear  = linear_speed(int'($signed(it.wheel_rate_one)), smin);
            cmd.drive_one_angular = turn_rate(err[0]);
        end
        if (it.has_wheel_two) begin
            cmd.drive_two_valid   = 1'b1;
            cmd.drive_two_linear  = linear_speed(int'($signed(it.wheel_rate_two)), smin);
            cmd.drive_two_angular = turn_rate(err[1]);
        end
        return 1'b1;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            radius_q12    = RADIUS_RST;
            drive_length  = LENGTH_RST;
            steer_meas[0] = '0;
            steer_meas[1] = '0;
            drive_cmd_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS: radius_q12 = i_cfg_data;
                    CFG_LENGTH: drive_length = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (predict_drive_cmd(i_in, want)) begin
                    drive_cmd_q.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_cmd_q.size() == 0) begin
                    $error("drive command transaction with nothing outstanding");
                    fails++;
                end else begin
                    want = drive_cmd_q.pop_front();
                    check_field("drive_one_valid", 16'(want.drive_one_valid),
                                16'(i_out.drive_one_valid));
                    check_field("drive_one_linear", want.drive_one_linear,
                                i_out.drive_one_linear);
                    check_field("drive_one_angular", want.drive_one_angular,
                                i_out.drive_one_angular);
                    check_field("drive_two_valid", 16'(want.drive_two_valid),
                                16'(i_out.drive_two_valid));
                    check_field("drive_two_linear", want.drive_two_linear,
                                i_out.drive_two_linear);
                    check_field("drive_two_angular", want.drive_two_angular,
                                i_out.drive_two_angular);
                end
            end
        end
        o_pending    = drive_cmd_q.size();
        o_fail_count = fails;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sasc_pkg::*;

    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_SEGMENTS = 10;
    localparam int SEGMENT_ITEMS   = 113;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in        = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RADIUS;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out_item            o_out;
    int                   fail_count;
    int                   pending_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    // Last measured angles handed to the block, used to aim command targets
    logic signed [ANG_W-1:0] sent_meas [2] = '{16'sd0, 16'sd0};

    always #6 i_clk = ~i_clk;

    steering_align_speed_scaler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sasc_drive_checker u_drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Receiver: random stalls, or a long hold-off when asked for one
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item steer_item(logic op, int hs1, int hs2, int a1, int a2,
                                            int hw1, int hw2, int r1, int r2);
        t_in_item it;
        it.op             = op;
        it.has_steer_one  = 1'(hs1);
        it.has_steer_two  = 1'(hs2);
        it.angle_one      = 16'(a1);
        it.angle_two      = 16'(a2);
        it.has_wheel_one  = 1'(hw1);
        it.has_wheel_two  = 1'(hw2);
        it.wheel_rate_one = 16'(r1);
        it.wheel_rate_two = 16'(r2);
        return it;
    endfunction

    // Spread steering errors over the scale bands, the wrap and the full range
    function automatic int steer_offset();
        int mag;
        case ($urandom_range(5))
            0: mag = $urandom_range(819);
            1: mag = $urandom_range(4096, 820);
            2: mag = $urandom_range(6600, 4097);
            3: mag = $urandom_range(26000, 12000);
            default: return int'($signed(16'($urandom)));
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic random_item(output t_in_item it);
        it.op             = ($urandom_range(99) < 30) ? OP_MEASURE : OP_COMMAND;
        it.has_steer_one  = ($urandom_range(99) < 85);
        it.has_steer_two  = ($urandom_range(99) < 85);
        it.angle_one      = 16'($urandom);
        it.angle_two      = 16'($urandom);
        it.has_wheel_one  = 1'($urandom_range(1));
        it.has_wheel_two  = 1'($urandom_range(1));
        it.wheel_rate_one = 16'($urandom);
        it.wheel_rate_two = 16'($urandom);
        if (it.op == OP_MEASURE) begin
            if ($urandom_range(1)) begin
                it.angle_one = 16'(steer_offset());
            end
            if ($urandom_range(1)) begin
                it.angle_two = 16'(steer_offset());
            end
        end else begin
            if ($urandom_range(3) != 0) begin
                it.angle_one = 16'(int'(sent_meas[0]) - steer_offset());
            end
            if ($urandom_range(3) != 0) begin
                it.angle_two = 16'(int'(sent_meas[1]) - steer_offset());
            end
            // Mostly both wheels, sometimes one, rarely none
            case ($urandom_range(9))
                0: {it.has_wheel_one, it.has_wheel_two} = 2'b00;
                1, 2: {it.has_wheel_one, it.has_wheel_two} = 2'b10;
                3, 4: {it.has_wheel_one, it.has_wheel_two} = 2'b01;
                default: {it.has_wheel_one, it.has_wheel_two} = 2'b11;
            endcase
            if ($urandom_range(9) == 0) begin
                it.wheel_rate_one = $urandom_range(1) ? 16'h7fff : 16'h8000;
            end
            if ($urandom_range(9) == 0) begin
                it.wheel_rate_two = $urandom_range(1) ? 16'h7fff : 16'h8000;
            end
        end
    endtask

    task automatic send_item(t_in_item it);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (it.op == OP_MEASURE) begin
            if (it.has_steer_one) begin
                sent_meas[0] = it.angle_one;
            end
            if (it.has_steer_two) begin
                sent_meas[1] = it.angle_two;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic set_config(logic [CFG_W-1:0] radius, logic [CFG_W-1:0] length);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_LENGTH, length);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then let the datapath go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in_item it;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(RADIUS_RST, LENGTH_RST);
        send_idle_pct = 9;
        recv_idle_pct = 84;

        send_item(steer_item(OP_MEASURE, 1, 1, 32767, -32768, 0, 0, 0, 0));
        send_item(steer_item(OP_COMMAND, 1, 1, -32768, 32767, 1, 1, 32767, -32768));
        send_item(steer_item(OP_MEASURE, 1, 1, 0, 0, 0, 0, 0, 0));
        send_item(steer_item(OP_COMMAND, 0, 0, 555, -555, 1, 1, 1, -1));
        send_item(steer_item(OP_COMMAND, 1, 1, -819, -820, 1, 1, 256, -256));
        send_item(steer_item(OP_COMMAND, 1, 1, -4096, -4097, 1, 0, 32767, 5));
        send_item(steer_item(OP_COMMAND, 1, 1, -6434, 6435, 0, 1, 0, -32768));
        send_item(steer_item(OP_COMMAND, 1, 1, 12868, -12869, 1, 1, 1000, -1000));
        send_item(steer_item(OP_COMMAND, 1, 1, -3000, 2048, 1, 1, 32767, 32767));
        send_item(steer_item(OP_COMMAND, 1, 1, 5, 5, 0, 0, 100, 100));
        send_item(steer_item(OP_MEASURE, 1, 0, 4000, 777, 1, 1, 9, 9));
        send_item(steer_item(OP_MEASURE, 0, 1, 123, -6000, 0, 0, 0, 0));
        send_item(steer_item(OP_COMMAND, 1, 1, 4000, -6000, 1, 1, -32768, 32767));
        send_item(steer_item(OP_COMMAND, 1, 0, -12000, 0, 0, 1, 300, 7000));
        send_item(steer_item(OP_MEASURE, 1, 1, -32768, 32767, 0, 0, 0, 0));
        send_item(steer_item(OP_COMMAND, 1, 1, 32767, -32768, 1, 1, -20000, 20000));

        // Zero drive length: turn rate pins by the sign of the error
        settle();
        set_config(16'hffff, '0);
        send_item(steer_item(OP_COMMAND, 1, 1, 0, 0, 1, 1, 32767, -32768));
        send_item(steer_item(OP_COMMAND, 1, 1, -32768, 32767, 1, 1, -32768, 32767));
        send_item(steer_item(OP_COMMAND, 0, 1, 0, -32768, 1, 1, 1234, -4321));

        settle();
        set_config('0, 16'd1);
        send_item(steer_item(OP_COMMAND, 1, 1, 1, -1, 1, 1, 32767, -32768));
        send_item(steer_item(OP_COMMAND, 1, 1, -900, 30000, 1, 1, 32767, 32767));

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            settle();
            case (seg)
                0: set_config(16'd4096, 16'd4096);
                1: set_config(16'hffff, 16'd1);
                3: set_config('0, 16'hffff);
                4: set_config(16'hffff, '0);
                5: set_config(16'($urandom), 16'($urandom_range(16)));
                6: set_config(RADIUS_RST, LENGTH_RST);
                8: set_config(16'hffff, 16'hffff);
                default: set_config(16'($urandom), 16'($urandom));
            endcase
            if (seg < 4) begin
                send_idle_pct = 9;
                recv_idle_pct = 84;
            end else if (seg < 7) begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Back up the output so the block has to stall its input
            if (seg == 7) begin
                hold_req = 1'b1;
            end
            repeat (SEGMENT_ITEMS) begin
                random_item(it);
                send_item(it);
            end
        end

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sasc_pkg.sv
rtl/sasc_ctrl.sv
rtl/sasc_dp.sv
rtl/steering_align_speed_scaler.sv
rtl/sasc_chk.sv
tb/sasc_drive_checker.sv
tb/tb.sv
